// ===== sv/asc_pkg.sv =====
// ----------------------------------------------------------------------------
// Alarm sensor code qualifier package
// Shared constants, codes and types for the qualifier, its sequencer and RAM.
// ----------------------------------------------------------------------------
package asc_pkg;

	// Table geometry
	localparam int NUM_ENTRIES = 32;
	localparam int IDX_W       = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
	localparam int CNT_W       = $clog2(NUM_ENTRIES + 1);
	// Wide enough to hold any entry number and any loaded index
	localparam int WIDE_W      = 9;

	// Field widths
	localparam int KIND_W  = 2;
	localparam int TIME_W  = 32;
	localparam int CODE_W  = 32;
	localparam int EIDX_W  = 5;
	localparam int GRP_W   = 2;
	localparam int CMD_W   = 3;
	localparam int BLANK_W = 16;

	localparam logic [BLANK_W-1:0] BLANK_RESET = 16'd1500;

	// Item kinds
	localparam logic [KIND_W-1:0] KIND_LOAD = 2'd0;
	localparam logic [KIND_W-1:0] KIND_RF   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CMD  = 2'd2;

	// Host commands
	localparam logic [CMD_W-1:0] CMD_ARM     = 3'd0;
	localparam logic [CMD_W-1:0] CMD_DISARM  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_SNIFF   = 3'd2;
	localparam logic [CMD_W-1:0] CMD_DISPLAY = 3'd3;
	localparam logic [CMD_W-1:0] CMD_LED     = 3'd4;

	// Entry groups
	localparam logic [GRP_W-1:0] GRP_DISARM     = 2'd0;
	localparam logic [GRP_W-1:0] GRP_ARM        = 2'd1;
	localparam logic [GRP_W-1:0] GRP_ALWAYS     = 2'd2;
	localparam logic [GRP_W-1:0] GRP_ARMED_ONLY = 2'd3;

	// One table entry as held in the RAM
	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic [GRP_W-1:0]  grp;
		logic [TIME_W-1:0] last;
	} ram_word_t;

	localparam int RAM_W = $bits(ram_word_t);

	// One input word as captured by the sequencer
	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [TIME_W-1:0] now_ms;
		logic [CODE_W-1:0] code;
		logic [EIDX_W-1:0] entry_index;
		logic [GRP_W-1:0]  entry_group;
		logic [CMD_W-1:0]  command;
	} item_t;

	// Sequencer status handed to the update logic
	typedef struct packed {
		logic              vld;
		item_t             item;
		logic              hit;
		logic [IDX_W-1:0]  hit_idx;
		logic [GRP_W-1:0]  hit_grp;
		logic [TIME_W-1:0] hit_last;
	} done_t;

endpackage

// ===== sv/asc_in_if.sv =====
// ----------------------------------------------------------------------------
// Qualifier input channel
// Valid/ready channel carrying one load, RF-code or command word.
// ----------------------------------------------------------------------------
interface asc_in_if;
	import asc_pkg::*;

	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [TIME_W-1:0] now_ms;
	logic [CODE_W-1:0] code;
	logic [EIDX_W-1:0] entry_index;
	logic [GRP_W-1:0]  entry_group;
	logic [CMD_W-1:0]  command;

	modport source (
		output valid, kind, now_ms, code, entry_index, entry_group, command,
		input  ready
	);

	modport sink (
		input  valid, kind, now_ms, code, entry_index, entry_group, command,
		output ready
	);

endinterface

// ===== sv/asc_out_if.sv =====
// ----------------------------------------------------------------------------
// Qualifier output channel
// Valid/ready channel carrying one result word per input word.
// ----------------------------------------------------------------------------
interface asc_out_if;
	import asc_pkg::*;

	logic              valid;
	logic              ready;
	logic              notify_known;
	logic              notify_unknown;
	logic [EIDX_W-1:0] matched_index;
	logic [CODE_W-1:0] code_echo;
	logic              armed;
	logic              led_on;
	logic              display_on;
	logic              sniffing_on;

	modport source (
		output valid, notify_known, notify_unknown, matched_index, code_echo,
		output armed, led_on, display_on, sniffing_on,
		input  ready
	);

	modport sink (
		input  valid, notify_known, notify_unknown, matched_index, code_echo,
		input  armed, led_on, display_on, sniffing_on,
		output ready
	);

endinterface

// ===== sv/asc_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module asc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== sv/asc_ctrl.sv =====
// ----------------------------------------------------------------------------
// Qualifier sequencer
// Captures one input word, scans the table RAM for an RF code word to find the first
// valid entry whose code matches, and holds the outcome until the update logic takes it.
// ----------------------------------------------------------------------------
module asc_ctrl (
	input  logic                              clk,
	input  logic                              arst_n,
	asc_in_if.sink                            in_ch,
	input  logic [asc_pkg::NUM_ENTRIES-1:0]   valid,
	input  asc_pkg::ram_word_t                rd_data,
	output logic                              rd_en,
	output logic [asc_pkg::IDX_W-1:0]         rd_addr,
	output asc_pkg::done_t                    done,
	input  logic                              take
);
	import asc_pkg::*;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SEARCH = 2'd1;
	localparam logic [1:0] ST_DONE   = 2'd2;

	logic [1:0]        state_q;
	item_t             item_q;
	logic [CNT_W-1:0]  rd_cnt_q;
	logic              cmp_vld_s1;
	logic [IDX_W-1:0]  cmp_idx_s1;
	logic              hit_q;
	logic [IDX_W-1:0]  hit_idx_q;
	logic [GRP_W-1:0]  hit_grp_q;
	logic [TIME_W-1:0] hit_last_q;
	logic              accept;
	logic              match;
	logic              last_cmp;

	assign in_ch.ready = (state_q == ST_IDLE);
	assign accept      = in_ch.valid && in_ch.ready;

	// Read side of the scan: one entry per cycle, lowest index first
	assign rd_en   = (state_q == ST_SEARCH) && (rd_cnt_q < CNT_W'(NUM_ENTRIES));
	assign rd_addr = rd_cnt_q[IDX_W-1:0];

	// Compare side: the data read in the previous cycle
	assign match    = cmp_vld_s1 && valid[cmp_idx_s1] && (rd_data.code == item_q.code);
	assign last_cmp = cmp_vld_s1 && (cmp_idx_s1 == IDX_W'(NUM_ENTRIES - 1));

	// Sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			rd_cnt_q   <= '0;
			cmp_vld_s1 <= 1'b0;
			hit_q      <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q    <= (in_ch.kind == KIND_RF) ? ST_SEARCH : ST_DONE;
						rd_cnt_q   <= '0;
						cmp_vld_s1 <= 1'b0;
						hit_q      <= 1'b0;
					end
				end
				ST_SEARCH: begin
					cmp_vld_s1 <= rd_en;
					if (rd_en) begin
						rd_cnt_q <= rd_cnt_q + CNT_W'(1);
					end
					if (match) begin
						hit_q   <= 1'b1;
						state_q <= ST_DONE;
					end else if (last_cmp) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					cmp_vld_s1 <= 1'b0;
					if (take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload: the captured word, the compare tag and the matched entry
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q.kind        <= in_ch.kind;
			item_q.now_ms      <= in_ch.now_ms;
			item_q.code        <= in_ch.code;
			item_q.entry_index <= in_ch.entry_index;
			item_q.entry_group <= in_ch.entry_group;
			item_q.command     <= in_ch.command;
		end
		cmp_idx_s1 <= rd_addr;
		if (state_q == ST_SEARCH && match) begin
			hit_idx_q  <= cmp_idx_s1;
			hit_grp_q  <= rd_data.grp;
			hit_last_q <= rd_data.last;
		end
	end

	assign done.vld      = (state_q == ST_DONE);
	assign done.item     = item_q;
	assign done.hit      = hit_q;
	assign done.hit_idx  = hit_idx_q;
	assign done.hit_grp  = hit_grp_q;
	assign done.hit_last = hit_last_q;

endmodule

// ===== sv/alarm_sensor_code_qualifier.sv =====
// A load or command word goes straight to its outcome; an RF code word first
// scans the table, up to NUM_ENTRIES entries, stopping at the first match.
// Throughput: one word at a time, set by the one-entry-per-cycle scan of the
// table RAM read port; back-pressure on the result adds to that.
// Reset: all table entries invalid, armed and display on, sniffing and LED off,
// blanking interval 1500 ms. The table RAM itself is not cleared.
// ----------------------------------------------------------------------------
// Alarm sensor code qualifier
// Matches received RF codes against a table of learnt devices, applies a shared
// blanking interval to each device and tracks the arm, display, LED and sniff flags.
// ----------------------------------------------------------------------------
module alarm_sensor_code_qualifier (
	input  logic                       clk,
	input  logic                       arst_n,
	asc_in_if.sink                     in_ch,
	asc_out_if.source                  out_ch,
	input  logic                       cfg_we,
	input  logic [asc_pkg::BLANK_W-1:0] cfg_wdata
);
	import asc_pkg::*;

	logic [BLANK_W-1:0]     blank_q;
	logic [NUM_ENTRIES-1:0] valid_q;
	logic                   armed_q;
	logic                   sniff_q;
	logic                   disp_q;
	logic                   led_q;

	done_t                  done;
	logic                   take;
	logic                   rd_en;
	logic [IDX_W-1:0]       rd_addr;
	ram_word_t              rd_data;
	logic                   ram_we;
	logic                   upd_we;
	logic [IDX_W-1:0]       ram_addr;
	ram_word_t              ram_wdata;

	logic [WIDE_W-1:0]      ld_ext;
	logic                   ld_ok;
	logic [WIDE_W-1:0]      hit_ext;
	logic [TIME_W-1:0]      age;
	logic                   pass;

	logic                   armed_d;
	logic                   sniff_d;
	logic                   disp_d;
	logic                   led_d;
	logic                   nk_d;
	logic                   nu_d;
	logic [EIDX_W-1:0]      mi_d;

	logic                   out_vld_q;
	logic                   nk_q;
	logic                   nu_q;
	logic [EIDX_W-1:0]      mi_q;
	logic [CODE_W-1:0]      code_q;
	logic                   armed_out_q;
	logic                   led_out_q;
	logic                   disp_out_q;
	logic                   sniff_out_q;

	// Table RAM: code, group and last-seen time of every entry
	asc_ram #(
		.WIDTH (RAM_W),
		.DEPTH (NUM_ENTRIES)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_addr),
		.wdata (ram_wdata),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	asc_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.valid   (valid_q),
		.rd_data (rd_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.done    (done),
		.take    (take)
	);

	// The outcome is taken once the result register is free
	assign take = done.vld && (!out_vld_q || out_ch.ready);

	// Load index range check and blanking test
	assign ld_ext  = WIDE_W'(done.item.entry_index);
	assign ld_ok   = (ld_ext < WIDE_W'(NUM_ENTRIES));
	assign hit_ext = WIDE_W'(done.hit_idx);
	assign age     = done.item.now_ms - done.hit_last;
	assign pass    = (age > TIME_W'(blank_q));

	// Effects of the finished word on flags, table and result
	always_comb begin
		armed_d   = armed_q;
		sniff_d   = sniff_q;
		disp_d    = disp_q;
		led_d     = led_q;
		nk_d      = 1'b0;
		nu_d      = 1'b0;
		mi_d      = '0;
		upd_we    = 1'b0;
		ram_addr  = done.hit_idx;
		ram_wdata.code = done.item.code;
		ram_wdata.grp  = done.hit_grp;
		ram_wdata.last = done.item.now_ms;
		case (done.item.kind)
			KIND_LOAD: begin
				if (ld_ok) begin
					upd_we         = 1'b1;
					ram_addr       = ld_ext[IDX_W-1:0];
					ram_wdata.grp  = done.item.entry_group;
					ram_wdata.last = '0;
				end
			end
			KIND_RF: begin
				if (done.hit) begin
					mi_d = hit_ext[EIDX_W-1:0];
					if (pass) begin
						upd_we = 1'b1;
						if (done.hit_grp != GRP_ARMED_ONLY || armed_q) begin
							led_d = 1'b1;
							nk_d  = 1'b1;
						end
						if (done.hit_grp == GRP_ARM) begin
							armed_d = 1'b1;
							disp_d  = 1'b0;
							led_d   = 1'b0;
						end else if (done.hit_grp == GRP_DISARM) begin
							armed_d = 1'b0;
							disp_d  = 1'b1;
							led_d   = 1'b0;
						end
					end
				end else begin
					nu_d = sniff_q;
				end
			end
			KIND_CMD: begin
				case (done.item.command)
					CMD_ARM:     armed_d = 1'b1;
					CMD_DISARM:  armed_d = 1'b0;
					CMD_SNIFF:   sniff_d = !sniff_q;
					CMD_DISPLAY: disp_d  = !disp_q;
					CMD_LED:     led_d   = !led_q;
					default:     ;
				endcase
			end
			default: ;
		endcase
	end

	assign ram_we = take && upd_we;

	// Blanking interval register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blank_q <= BLANK_RESET;
		end else if (cfg_we) begin
			blank_q <= cfg_wdata;
		end
	end

	// Entry valid marks and system flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			armed_q <= 1'b1;
			sniff_q <= 1'b0;
			disp_q  <= 1'b1;
			led_q   <= 1'b0;
		end else if (take) begin
			if (done.item.kind == KIND_LOAD && ld_ok) begin
				valid_q[ld_ext[IDX_W-1:0]] <= 1'b1;
			end
			armed_q <= armed_d;
			sniff_q <= sniff_d;
			disp_q  <= disp_d;
			led_q   <= led_d;
		end
	end

	// Result register: valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (take) begin
			out_vld_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	// Result register: payload
	always_ff @(posedge clk) begin
		if (take) begin
			nk_q        <= nk_d;
			nu_q        <= nu_d;
			mi_q        <= mi_d;
			code_q      <= done.item.code;
			armed_out_q <= armed_d;
			led_out_q   <= led_d;
			disp_out_q  <= disp_d;
			sniff_out_q <= sniff_d;
		end
	end

	assign out_ch.valid          = out_vld_q;
	assign out_ch.notify_known   = nk_q;
	assign out_ch.notify_unknown = nu_q;
	assign out_ch.matched_index  = mi_q;
	assign out_ch.code_echo      = code_q;
	assign out_ch.armed          = armed_out_q;
	assign out_ch.led_on         = led_out_q;
	assign out_ch.display_on     = disp_out_q;
	assign out_ch.sniffing_on    = sniff_out_q;

	// A new word is never accepted while an outcome waits to be taken
	a_no_accept_when_done: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready) |-> !done.vld)
		else $error("input word accepted while an outcome is pending");

	// The table is written only when an outcome is taken
	a_write_on_take: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> take)
		else $error("table written outside of an outcome hand-over");

	// A result word never reports a known and an unknown event together
	a_notify_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> !(out_ch.notify_known && out_ch.notify_unknown))
		else $error("known and unknown notify raised together");

	// Valid marks are never lost once set
	a_valid_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) >= $countones($past(valid_q)))
		else $error("table entry lost its valid mark");

endmodule

// ===== dv/tb_alarm_sensor_code_qualifier.sv =====
// ----------------------------------------------------------------------------
// Alarm sensor code qualifier testbench
// Drives load, RF-code and command words through the input channel and checks every
// result word against a pinned result or an in-bench model of the device table,
// blanking and flags. A short table of hand-picked words comes first, then randomised
// sessions under several blanking intervals, with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_alarm_sensor_code_qualifier;
	timeunit 1ns;
	timeprecision 1ps;
	import asc_pkg::*;

	localparam int          RESET_CYCLES = 5;
	localparam int          IDLE_PCT     = 28;
	localparam int          HOLD_CYCLES  = 400;
	localparam int          CHUNK_WORDS  = 155;
	localparam int          PHASES       = 6;
	localparam int          PLAN_ROWS    = 25;
	localparam int          END_TAIL     = 64;
	localparam int unsigned CYCLE_LIMIT  = 1_000_000;

	// Values outside the defined kinds and commands
	localparam logic [KIND_W-1:0] KIND_BAD = 2'd3;
	localparam logic [CMD_W-1:0]  CMD_BAD  = 3'd7;

	// One result word as seen on the output channel
	typedef struct packed {
		logic              notify_known;
		logic              notify_unknown;
		logic [EIDX_W-1:0] matched_index;
		logic [CODE_W-1:0] code_echo;
		logic              armed;
		logic              led_on;
		logic              display_on;
		logic              sniffing_on;
	} verdict_t;

	// One input word, with a hand-written result where the table gives one
	typedef struct packed {
		item_t    item;
		logic     pinned;
		verdict_t want;
	} stim_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_we;
	logic [BLANK_W-1:0]  cfg_wdata;

	asc_in_if  in_ch ();
	asc_out_if out_ch ();

	alarm_sensor_code_qualifier u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// Device table and flag model
	logic [CODE_W-1:0]  dev_code  [NUM_ENTRIES];
	logic [GRP_W-1:0]   dev_group [NUM_ENTRIES];
	logic               dev_valid [NUM_ENTRIES];
	logic [TIME_W-1:0]  dev_last  [NUM_ENTRIES];
	logic               st_armed   = 1'b1;
	logic               st_sniff   = 1'b0;
	logic               st_display = 1'b1;
	logic               st_led     = 1'b0;
	logic [BLANK_W-1:0] blank_ms   = BLANK_RESET;

	stim_t             pending_words [$];
	verdict_t          awaited_results [$];
	stim_t             plan [PLAN_ROWS];
	stim_t             held;
	logic [CODE_W-1:0] learnt_codes [$];
	logic [TIME_W-1:0] gen_now = '0;

	int          err_count   = 0;
	int unsigned cycle_count = 0;
	logic        calm        = 1'b0;
	logic        hold_req    = 1'b0;
	logic        hold_done   = 1'b0;
	int          hold_left   = 0;

	// Clock: 10 ns period.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Works out the result word for one accepted input word and updates the model.
	function automatic verdict_t qualify_word(input item_t w);
		verdict_t          v;
		int                hit;
		logic [TIME_W-1:0] gap;
		v           = '0;
		v.code_echo = w.code;
		hit         = -1;
		case (w.kind)
			KIND_LOAD: begin
				if (int'(w.entry_index) < NUM_ENTRIES) begin
					dev_code[w.entry_index]  = w.code;
					dev_group[w.entry_index] = w.entry_group;
					dev_valid[w.entry_index] = 1'b1;
					dev_last[w.entry_index]  = '0;
				end
			end
			KIND_RF: begin
				for (int i = 0; i < NUM_ENTRIES; i++) begin
					if (hit < 0 && dev_valid[i] && dev_code[i] == w.code)
						hit = i;
				end
				if (hit >= 0) begin
					v.matched_index = EIDX_W'(hit);
					gap = w.now_ms - dev_last[hit];
					if (gap > TIME_W'(blank_ms)) begin
						dev_last[hit] = w.now_ms;
						if (dev_group[hit] != GRP_ARMED_ONLY || st_armed) begin
							st_led         = 1'b1;
							v.notify_known = 1'b1;
						end
						if (dev_group[hit] == GRP_ARM) begin
							st_armed   = 1'b1;
							st_display = 1'b0;
							st_led     = 1'b0;
						end else if (dev_group[hit] == GRP_DISARM) begin
							st_armed   = 1'b0;
							st_display = 1'b1;
							st_led     = 1'b0;
						end
					end
				end else if (st_sniff) begin
					v.notify_unknown = 1'b1;
				end
			end
			KIND_CMD: begin
				case (w.command)
					CMD_ARM:     st_armed   = 1'b1;
					CMD_DISARM:  st_armed   = 1'b0;
					CMD_SNIFF:   st_sniff   = !st_sniff;
					CMD_DISPLAY: st_display = !st_display;
					CMD_LED:     st_led     = !st_led;
					default: ;
				endcase
			end
			default: ;
		endcase
		v.armed       = st_armed;
		v.led_on      = st_led;
		v.display_on  = st_display;
		v.sniffing_on = st_sniff;
		return v;
	endfunction

	// Builds one table row without a hand-written result.
	function automatic stim_t word(input logic [KIND_W-1:0] kind, input logic [TIME_W-1:0] now,
		input logic [CODE_W-1:0] code, input logic [EIDX_W-1:0] idx,
		input logic [GRP_W-1:0] grp, input logic [CMD_W-1:0] cmd);
		stim_t s;
		s                  = '0;
		s.item.kind        = kind;
		s.item.now_ms      = now;
		s.item.code        = code;
		s.item.entry_index = idx;
		s.item.entry_group = grp;
		s.item.command     = cmd;
		return s;
	endfunction

	// Attaches a hand-written result to a table row.
	function automatic stim_t pin(input stim_t s, input logic nk, input logic nu,
		input logic [CODE_W-1:0] code, input logic arm, input logic led,
		input logic disp, input logic sniff);
		stim_t r;
		r                      = s;
		r.pinned               = 1'b1;
		r.want                 = '0;
		r.want.notify_known    = nk;
		r.want.notify_unknown  = nu;
		r.want.code_echo       = code;
		r.want.armed           = arm;
		r.want.led_on          = led;
		r.want.display_on      = disp;
		r.want.sniffing_on     = sniff;
		return r;
	endfunction

	// Prints one line per mismatch and counts them all.
	task automatic flag_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		err_count++;
		$display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
	endtask

	// Queues randomised words: mostly RF codes of learnt devices on a moving clock.
	task automatic make_words(input int n);
		stim_t       s;
		int          r;
		int          p;
		int unsigned span;
		span = 2 * int'(blank_ms) + 16;
		for (int k = 0; k < n; k++) begin
			s                  = '0;
			s.item.now_ms      = $urandom;
			s.item.code        = $urandom;
			s.item.entry_index = EIDX_W'($urandom);
			s.item.entry_group = GRP_W'($urandom);
			s.item.command     = CMD_W'($urandom);
			r = $urandom_range(0, 99);
			if (r < 14) begin
				s.item.kind = KIND_LOAD;
				// Some loads reuse a learnt code, so that duplicates sit in the table.
				if (learnt_codes.size() != 0 && $urandom_range(0, 3) == 0)
					s.item.code = learnt_codes[$urandom_range(0, learnt_codes.size() - 1)];
				learnt_codes.push_back(s.item.code);
			end else if (r < 68) begin
				s.item.kind = KIND_RF;
				p = $urandom_range(0, 99);
				if (p < 3)
					gen_now = $urandom;
				else if (p < 6)
					gen_now = 32'hFFFF_FF00 | TIME_W'($urandom_range(0, 255));
				else
					gen_now = gen_now + $urandom_range(0, span);
				s.item.now_ms = gen_now;
				if (learnt_codes.size() != 0 && $urandom_range(0, 99) < 75)
					s.item.code = learnt_codes[$urandom_range(0, learnt_codes.size() - 1)];
			end else if (r < 92) begin
				s.item.kind = KIND_CMD;
				if ($urandom_range(0, 99) < 93)
					s.item.command = CMD_W'($urandom_range(CMD_ARM, CMD_LED));
				else
					s.item.command = CMD_W'($urandom_range(CMD_LED + 1, CMD_BAD));
			end else begin
				s.item.kind = KIND_BAD;
			end
			pending_words.push_back(s);
		end
	endtask

	// Waits until every queued word has gone in and every result word has come back.
	// Sampled at the falling edge, so that all updates of the rising edge are seen.
	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_words.size() != 0 || in_ch.valid || awaited_results.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	// Writes the blanking interval while the block is idle.
	task automatic set_blanking(input logic [BLANK_W-1:0] v);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		blank_ms  = v;
	endtask

	// Input side: offers queued words, idling at random, and predicts each accepted one.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready)
				awaited_results.push_back(held.pinned ? held.want : qualify_word(held.item));
			if (held.pinned && in_ch.valid && in_ch.ready)
				void'(qualify_word(held.item));
			if (!in_ch.valid || in_ch.ready) begin
				if (pending_words.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
					held = pending_words.pop_front();
					in_ch.kind        <= held.item.kind;
					in_ch.now_ms      <= held.item.now_ms;
					in_ch.code        <= held.item.code;
					in_ch.entry_index <= held.item.entry_index;
					in_ch.entry_group <= held.item.entry_group;
					in_ch.command     <= held.item.command;
					in_ch.valid       <= 1'b1;
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Output side: random stalls, plus one long hold-off counted here.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left    <= hold_left - 1;
			out_ch.ready <= 1'b0;
		end else if (hold_req && !hold_done) begin
			hold_left    <= HOLD_CYCLES;
			hold_done    <= 1'b1;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	// Result checking against the oldest awaited word, field by field.
	always @(posedge clk) begin
		verdict_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (awaited_results.size() == 0) begin
				flag_mismatch("result word with none awaited, code", out_ch.code_echo, '0);
			end else begin
				want = awaited_results.pop_front();
				if (out_ch.notify_known !== want.notify_known)
					flag_mismatch("notify_known", 32'(out_ch.notify_known),
						32'(want.notify_known));
				if (out_ch.notify_unknown !== want.notify_unknown)
					flag_mismatch("notify_unknown", 32'(out_ch.notify_unknown),
						32'(want.notify_unknown));
				if (out_ch.matched_index !== want.matched_index)
					flag_mismatch("matched_index", 32'(out_ch.matched_index),
						32'(want.matched_index));
				if (out_ch.code_echo !== want.code_echo)
					flag_mismatch("code_echo", out_ch.code_echo, want.code_echo);
				if (out_ch.armed !== want.armed)
					flag_mismatch("armed", 32'(out_ch.armed), 32'(want.armed));
				if (out_ch.led_on !== want.led_on)
					flag_mismatch("led_on", 32'(out_ch.led_on), 32'(want.led_on));
				if (out_ch.display_on !== want.display_on)
					flag_mismatch("display_on", 32'(out_ch.display_on),
						32'(want.display_on));
				if (out_ch.sniffing_on !== want.sniffing_on)
					flag_mismatch("sniffing_on", 32'(out_ch.sniffing_on),
						32'(want.sniffing_on));
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Reset, the directed table, then randomised sessions under several intervals.
	initial begin
		logic [BLANK_W-1:0] blanks [PHASES];
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_wdata         = '0;
		in_ch.valid       = 1'b0;
		in_ch.kind        = '0;
		in_ch.now_ms      = '0;
		in_ch.code        = '0;
		in_ch.entry_index = '0;
		in_ch.entry_group = '0;
		in_ch.command     = '0;
		out_ch.ready      = 1'b0;
		held              = '0;
		for (int i = 0; i < NUM_ENTRIES; i++) begin
			dev_code[i]  = '0;
			dev_group[i] = '0;
			dev_valid[i] = 1'b0;
			dev_last[i]  = '0;
		end
		blanks = '{16'd0, 16'hFFFF, 16'd1, BLANK_W'($urandom), BLANK_RESET, BLANK_W'($urandom)};

		plan = '{
			// Empty table after reset, sniffing off: nothing reported.
			pin(word(KIND_RF, 32'd0, 32'h1234_5678, '0, '0, '0),
				1'b0, 1'b0, 32'h1234_5678, 1'b1, 1'b0, 1'b1, 1'b0),
			pin(word(KIND_CMD, '0, '0, '0, '0, CMD_SNIFF),
				1'b0, 1'b0, 32'h0, 1'b1, 1'b0, 1'b1, 1'b1),
			// Unknown code while sniffing, at the top of both ranges.
			pin(word(KIND_RF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0, '0, '0),
				1'b0, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b1, 1'b1),
			pin(word(KIND_LOAD, '0, 32'hA5A5_A5A5, 5'd0, GRP_ARMED_ONLY, '0),
				1'b0, 1'b0, 32'hA5A5_A5A5, 1'b1, 1'b0, 1'b1, 1'b1),
			pin(word(KIND_LOAD, '0, 32'hFFFF_FFFF, 5'd31, GRP_ALWAYS, '0),
				1'b0, 1'b0, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b1, 1'b1),
			word(KIND_LOAD, '0, 32'h0000_0000, 5'd1, GRP_ARM, '0),
			word(KIND_LOAD, '0, 32'h0000_0001, 5'd2, GRP_DISARM, '0),
			// A duplicate code further up: the lower entry must win.
			word(KIND_LOAD, '0, 32'hA5A5_A5A5, 5'd3, GRP_ALWAYS, '0),
			// Exactly at the interval is still blanked; one past it is not.
			word(KIND_RF, 32'd1500, 32'hA5A5_A5A5, '0, '0, '0),
			word(KIND_RF, 32'd1501, 32'hA5A5_A5A5, '0, '0, '0),
			word(KIND_RF, 32'd2000, 32'hA5A5_A5A5, '0, '0, '0),
			word(KIND_RF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0, '0, '0),
			word(KIND_RF, 32'hFFFF_FFFF, 32'h0000_0000, '0, '0, '0),
			word(KIND_RF, 32'hFFFF_FFFF, 32'h0000_0001, '0, '0, '0),
			// Time wrapped past zero; report-when-armed device while disarmed.
			word(KIND_RF, 32'h0000_0100, 32'hA5A5_A5A5, '0, '0, '0),
			word(KIND_CMD, '0, '0, '0, '0, CMD_ARM),
			word(KIND_RF, 32'h0000_1000, 32'hA5A5_A5A5, '0, '0, '0),
			word(KIND_CMD, '0, '0, '0, '0, CMD_DISARM),
			word(KIND_CMD, '0, '0, '0, '0, CMD_DISPLAY),
			word(KIND_CMD, '0, '0, '0, '0, CMD_LED),
			// Undefined command and undefined kind change nothing.
			word(KIND_CMD, '0, 32'h0BAD_C0DE, '0, '0, CMD_BAD),
			word(KIND_BAD, 32'h7FFF_FFFF, 32'hDEAD_BEEF, 5'd17, GRP_ARM, CMD_ARM),
			word(KIND_CMD, '0, '0, '0, '0, CMD_SNIFF),
			word(KIND_RF, 32'd0, 32'h5555_AAAA, '0, '0, '0),
			// Reloading an entry clears its last-seen time.
			word(KIND_LOAD, '0, 32'h5555_AAAA, 5'd0, GRP_ALWAYS, '0)
		};

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < PLAN_ROWS; i++)
			pending_words.push_back(plan[i]);
		wait_drained();

		for (int ph = 0; ph < PHASES; ph++) begin
			set_blanking(blanks[ph]);
			for (int ch = 0; ch < 2; ch++) begin
				calm <= (ph == 1 && ch == 1);
				if (ph == 3 && ch == 0)
					hold_req <= 1'b1;
				make_words(CHUNK_WORDS);
				wait_drained();
			end
		end

		repeat (END_TAIL) @(posedge clk);
		if (awaited_results.size() != 0)
			flag_mismatch("result words never delivered", awaited_results.size(), '0);
		if (err_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
